// ===== rtl/mbp_pkg.sv =====
package mbp_pkg;

  localparam int VALUE_W     = 64;
  localparam int COUNT_W     = 7;
  localparam int BYTE_W      = 8;
  localparam int ACC_W       = BYTE_W - 1;
  localparam int FILL_W      = 3;
  localparam int MAX_BITS    = 64;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_APPEND,
    OP_FLUSH
  } op_t;

  // Queue entry: append bits are left-aligned, first bit in the MSB.
  typedef struct packed {
    op_t                 op;
    logic [VALUE_W-1:0]  bits;
    logic [COUNT_W-1:0]  count;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_FLUSH
  } back_state_t;

endpackage

// ===== rtl/msb_first_bit_packer_core.sv =====
// Channel | Handshake               | Payload
// --------+-------------------------+------------------------------
// item    | item_valid / item_ready | cmd, value, bit_count
// byte    | byte_valid / byte_ready | out_byte, last
//
// An item is written into the queue, then popped and loaded into the back end, which
// emits its bytes one at a time: up to eight for an append (none when it only fills
// the accumulator), at most one for a flush. The back end's byte loop sets the rate.
// Synchronous reset clears the queue, the accumulator and byte_valid (not out_byte/last).
// A stalled byte channel holds the back end; the front keeps taking items until the
// queue fills. Dropped appends (zero or too many bits) never enter the queue.
module msb_first_bit_packer_core #(
  parameter int QUEUE_DEPTH = mbp_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic                         cmd,
  input  logic [mbp_pkg::VALUE_W-1:0]  value,
  input  logic [mbp_pkg::COUNT_W-1:0]  bit_count,
  output logic                         byte_valid,
  input  logic                         byte_ready,
  output logic [mbp_pkg::BYTE_W-1:0]   out_byte,
  output logic                         last
);
  import mbp_pkg::*;

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   full;
  logic   pop;
  logic   not_empty;

  mbp_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .value      (value),
    .bit_count  (bit_count),
    .q_full     (full),
    .q_push     (push),
    .q_entry    (push_entry)
  );

  mbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  mbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (not_empty),
    .q_entry    (head),
    .q_pop      (pop),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule

// ===== rtl/mbp_front.sv =====
module mbp_front (
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic                           cmd,
  input  logic [mbp_pkg::VALUE_W-1:0]    value,
  input  logic [mbp_pkg::COUNT_W-1:0]    bit_count,
  input  logic                           q_full,
  output logic                           q_push,
  output mbp_pkg::entry_t                q_entry
);
  import mbp_pkg::*;

  logic                drop;
  logic [COUNT_W-1:0]  shamt;

  // Appends of zero bits or more than MAX_BITS bits have no effect: drop them here.
  assign drop = (cmd == 1'b0) &&
                ((bit_count == '0) || (bit_count > COUNT_W'(MAX_BITS)));

  assign item_ready = !q_full;
  assign q_push     = item_valid && item_ready && !drop;

  assign shamt = COUNT_W'(VALUE_W) - bit_count;

  always_comb begin
    q_entry.op    = cmd ? OP_FLUSH : OP_APPEND;
    q_entry.bits  = value << shamt[COUNT_W-2:0];
    q_entry.count = bit_count;
  end

endmodule

// ===== rtl/mbp_queue.sv =====
module mbp_queue #(
  parameter int DEPTH = mbp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mbp_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output mbp_pkg::entry_t head
);
  import mbp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t              slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    fill;

  assign full      = (fill == CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mbp_back.sv =====
module mbp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  mbp_pkg::entry_t             q_entry,
  output logic                        q_pop,
  output logic                        byte_valid,
  input  logic                        byte_ready,
  output logic [mbp_pkg::BYTE_W-1:0]  out_byte,
  output logic                        last
);
  import mbp_pkg::*;

  back_state_t          state, state_next;
  logic [ACC_W-1:0]     acc;
  logic [FILL_W-1:0]    pcnt;
  logic [VALUE_W-1:0]   val;
  logic [COUNT_W-1:0]   rem;

  logic                 step;
  logic                 emit;
  logic                 done;
  logic [3:0]           k;
  logic [COUNT_W-1:0]   total;
  logic [COUNT_W-1:0]   rem_after;
  logic [VALUE_W-1:0]   val_after;
  logic [BYTE_W-1:0]    hi;
  logic [BYTE_W-1:0]    lo;
  logic [BYTE_W-1:0]    absorb;
  logic [BYTE_W-1:0]    tail;
  logic [BYTE_W-1:0]    byte_next;
  logic                 last_next;

  // Step datapath: bytes are cut from {acc, val} where val is left-aligned.
  always_comb begin
    k         = 4'd8 - {1'b0, pcnt};
    total     = {{(COUNT_W-FILL_W){1'b0}}, pcnt} + rem;
    hi        = BYTE_W'({1'b0, acc} << k);
    lo        = val[VALUE_W-1 -: BYTE_W] >> pcnt;
    rem_after = rem - {{(COUNT_W-4){1'b0}}, k};
    val_after = val << k;
    tail      = val_after[VALUE_W-1 -: BYTE_W] >> (4'd8 - rem_after[3:0]);
    absorb    = BYTE_W'({1'b0, acc} << rem[3:0]) |
                (val[VALUE_W-1 -: BYTE_W] >> (4'd8 - rem[3:0]));
  end

  // Output block
  always_comb begin
    step      = 1'b0;
    emit      = 1'b0;
    done      = 1'b0;
    q_pop     = 1'b0;
    byte_next = hi | lo;
    last_next = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_pop = q_valid;
      end
      ST_APPEND: begin
        step = !byte_valid || byte_ready;
        if (total >= COUNT_W'(BYTE_W)) begin
          emit      = step;
          last_next = (rem_after < COUNT_W'(BYTE_W));
          done      = step && last_next;
        end else begin
          done = step;
        end
      end
      ST_FLUSH: begin
        step      = !byte_valid || byte_ready;
        emit      = step && (pcnt != '0);
        done      = step;
        byte_next = hi;
        last_next = 1'b1;
      end
      default: begin
        step = 1'b0;
      end
    endcase
  end

  // Next-state block
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_entry.op == OP_FLUSH) ? ST_FLUSH : ST_APPEND;
        end
      end
      ST_APPEND, ST_FLUSH: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      acc        <= '0;
      pcnt       <= '0;
      byte_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        byte_valid <= 1'b1;
      end else if (byte_ready) begin
        byte_valid <= 1'b0;
      end
      if (state == ST_FLUSH && step) begin
        acc  <= '0;
        pcnt <= '0;
      end else if (state == ST_APPEND && step) begin
        if (emit && last_next) begin
          acc  <= tail[ACC_W-1:0];
          pcnt <= rem_after[FILL_W-1:0];
        end else if (emit) begin
          acc  <= '0;
          pcnt <= '0;
        end else begin
          acc  <= absorb[ACC_W-1:0];
          pcnt <= total[FILL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      val <= q_entry.bits;
      rem <= q_entry.count;
    end else if (state == ST_APPEND && emit) begin
      val <= val_after;
      rem <= rem_after;
    end
    if (emit) begin
      out_byte <= byte_next;
      last     <= last_next;
    end
  end

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && step) |=> (pcnt == '0 && state == ST_IDLE))
    else $error("flush left bits pending");

  a_mid_byte_continues: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPEND && emit && !last_next) |=>
      (state == ST_APPEND && rem >= COUNT_W'(BYTE_W)))
    else $error("append ended before its last byte");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE && q_valid))
    else $error("queue popped while busy");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    (emit && byte_valid) |-> byte_ready)
    else $error("byte overwritten before taken");

endmodule

// ===== test/msb_first_bit_packer_core_test.sv =====
module msb_first_bit_packer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_GAP     = 10;
  localparam int DRAIN_WAIT  = 24;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  logic                cmd = OP_APPEND;
  logic [VALUE_W-1:0]  value = '0;
  logic [COUNT_W-1:0]  bit_count = '0;
  logic                byte_valid;
  logic                byte_ready = 1'b0;
  logic [BYTE_W-1:0]   out_byte;
  logic                last;

  // predictor state: pending bits right-aligned, oldest bit highest
  logic [ACC_W-1:0]    acc_bits = '0;
  logic [FILL_W-1:0]   acc_fill = '0;
  packed_byte_t        bytes_due[$];

  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  int sink_hold = 0;

  int cycle_count = 0;
  int errors = 0;
  int items_sent = 0;
  int items_dropped = 0;
  int flushes_sent = 0;
  int bytes_checked = 0;

  msb_first_bit_packer_core uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .value      (value),
    .bit_count  (bit_count),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .out_byte   (out_byte),
    .last       (last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycle_count, bytes_due.size());
      $display("msb_first_bit_packer_core regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Work out the bytes one accepted transaction produces and advance the packer state.
  task automatic predict_bytes(op_t op, logic [VALUE_W-1:0] v, logic [COUNT_W-1:0] n);
    logic [BYTE_W-1:0] acc;
    int fill;
    int nbytes;
    int produced;
    packed_byte_t e;
    if (op == OP_FLUSH) begin
      flushes_sent++;
      if (acc_fill != 0) begin
        acc = {1'b0, acc_bits};
        acc = acc << (BYTE_W - int'(acc_fill));
        e.data = acc;
        e.last = 1'b1;
        bytes_due.push_back(e);
      end
      acc_bits = '0;
      acc_fill = '0;
      return;
    end
    if (n == 0 || int'(n) > MAX_BITS) begin
      items_dropped++;
      return;
    end
    acc = {1'b0, acc_bits};
    fill = int'(acc_fill);
    nbytes = (fill + int'(n)) / BYTE_W;
    produced = 0;
    for (int i = int'(n) - 1; i >= 0; i--) begin
      acc = {acc[BYTE_W-2:0], v[i]};
      fill++;
      if (fill == BYTE_W) begin
        produced++;
        e.data = acc;
        e.last = (produced == nbytes);
        bytes_due.push_back(e);
        acc = '0;
        fill = 0;
      end
    end
    acc_bits = acc[ACC_W-1:0];
    acc_fill = fill[FILL_W-1:0];
  endtask

  // Entered and left at a falling edge; valid stays up between back-to-back transactions.
  task automatic send_item(op_t op, logic [VALUE_W-1:0] v, logic [COUNT_W-1:0] n);
    int gap;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd = op;
    value = v;
    bit_count = n;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    items_sent++;
    predict_bytes(op, v, n);
    @(negedge clk);
  endtask

  task automatic random_item(output op_t op, output logic [VALUE_W-1:0] v,
                             output logic [COUNT_W-1:0] n);
    int kind;
    kind = $urandom_range(0, 15);
    v = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0)
      v = $urandom_range(0, 1) ? '1 : '0;
    op = OP_APPEND;
    if (kind < 2) begin
      op = OP_FLUSH;
      n = COUNT_W'($urandom_range(0, 127));
    end else if (kind == 2) begin
      n = $urandom_range(0, 1) ? '0 : COUNT_W'($urandom_range(MAX_BITS + 1, 127));
    end else if (kind < 5) begin
      n = COUNT_W'(MAX_BITS);
    end else if (kind < 10) begin
      n = COUNT_W'($urandom_range(1, 8));
    end else begin
      n = COUNT_W'($urandom_range(1, MAX_BITS));
    end
  endtask

  // Dropped appends do not count toward the target.
  task automatic send_random(int target);
    op_t op;
    logic [VALUE_W-1:0] v;
    logic [COUNT_W-1:0] n;
    int done;
    done = 0;
    while (done < target) begin
      random_item(op, v, n);
      send_item(op, v, n);
      if (op == OP_FLUSH || (n != 0 && int'(n) <= MAX_BITS))
        done++;
    end
  endtask

  task automatic test_directed_edges();
    send_item(OP_APPEND, 64'h1, 7'd1);
    send_item(OP_FLUSH, '0, '0);
    send_item(OP_FLUSH, '0, '0);                       // nothing pending
    send_item(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFA5, 7'd8); // upper bits ignored
    send_item(OP_APPEND, '1, 7'd64);
    send_item(OP_APPEND, '0, 7'd64);
    send_item(OP_APPEND, 64'h0123_4567_89AB_CDEF, 7'd64);
    send_item(OP_APPEND, 64'h55, 7'd7);
    send_item(OP_APPEND, 64'h0, 7'd1);
    send_item(OP_APPEND, '1, 7'd7);
    send_item(OP_FLUSH, '0, '0);                       // widest partial byte
    send_item(OP_APPEND, 64'h5, 7'd3);
    send_item(OP_APPEND, 64'hF0E1_D2C3_B4A5_9687, 7'd64);
    send_item(OP_APPEND, '1, 7'd0);                    // zero count, dropped
    send_item(OP_APPEND, '1, 7'd65);                   // above max, dropped
    send_item(OP_APPEND, '1, 7'd127);
    send_item(OP_FLUSH, '1, 7'd127);                   // payload ignored on flush
    send_item(OP_APPEND, '1, 7'd5);
    send_item(OP_APPEND, 64'h8000_0000_0000_0001, 7'd64);
    send_item(OP_FLUSH, '0, 7'd64);
  endtask

  task automatic test_back_to_back();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    send_random(40);
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  task automatic test_output_stall();
    src_idle = 1'b0;
    sink_hold = 300;
    for (int i = 0; i < 30; i++)
      send_item(OP_APPEND, {$urandom, $urandom}, COUNT_W'(MAX_BITS - (i % 3) * 17));
    src_idle = 1'b1;
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 4; phase++) begin
      src_idle = (phase != 2);
      sink_idle = (phase != 1);
      send_random(51);
    end
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // byte sink: random stalls per byte, plus a long hold-off on request
  initial begin : byte_sink
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (sink_hold > 0) begin
        byte_ready = 1'b0;
        repeat (sink_hold) @(negedge clk);
        sink_hold = 0;
      end
      stall = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        byte_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      byte_ready = 1'b1;
      do @(posedge clk); while (!byte_valid && sink_hold == 0);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    packed_byte_t e;
    if (!rst && byte_valid && byte_ready) begin
      if (bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, last));
      end else begin
        e = bytes_due.pop_front();
        bytes_checked++;
        if (out_byte !== e.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, e.data));
        if (last !== e.last)
          report_mismatch($sformatf("last %0b, expected %0b (byte %02h)", last, e.last,
                                    e.data));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_directed_edges();
    test_back_to_back();
    test_output_stall();
    test_random_mix();
    item_valid = 1'b0;

    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (bytes_due.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never arrived", bytes_due.size()));

    $display("covered %0d transactions (%0d flushes, %0d dropped appends), %0d bytes checked",
             items_sent, flushes_sent, items_dropped, bytes_checked);
    $display("with back-to-back, randomly gapped and long-stalled byte output; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("msb_first_bit_packer_core regression: pass");
    end else begin
      $display("msb_first_bit_packer_core regression: fail");
    end
    $finish;
  end

endmodule
